// File: hw/rtl/sawm_pkg.sv
// Shared constants, request codes and control types for the anagram window matcher.
package sawm_pkg;

  localparam int unsigned LETTER_W     = 5;
  localparam int unsigned ALPHABET     = 26;
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned S_DATA_W     = ((LETTER_W + 7) / 8) * 8;
  localparam int unsigned MAX_PAT_DEF  = 64;
  localparam int unsigned POS_BITS_DEF = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_PATTERN = 2'd0,
    REQ_TEXT    = 2'd1,
    REQ_CLEAR   = 2'd2
  } req_e;

  typedef logic [LETTER_W-1:0] letter_t;

  // Histogram update requests for one item, qualified by the pipeline advance.
  typedef struct packed {
    logic    clear;
    logic    pat_inc;
    logic    win_inc;
    logic    win_dec;
    letter_t letter;
    letter_t old_letter;
  } hist_ctrl_t;

endpackage

// File: hw/rtl/sawm_ring.sv
// Letter ring memory with one write port and a registered, write-forwarded read port.
module sawm_ring import sawm_pkg::*; #(
  parameter int unsigned DEPTH = MAX_PAT_DEF,
  parameter int unsigned PTR_W = 6
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [PTR_W-1:0] wr_addr_i,
  input  letter_t          wr_data_i,
  input  logic [PTR_W-1:0] rd_addr_i,
  output letter_t          rd_data_o
);

  letter_t mem [DEPTH];
  letter_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // A one-letter window reads back the entry written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_data_q <= wr_data_i;
    end else begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/sawm_hist.sv
// Pattern and window histograms, one counter lane per letter, with a parallel compare.
module sawm_hist import sawm_pkg::*; #(
  parameter int unsigned CNT_W = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  hist_ctrl_t ctrl_i,
  output logic       equal_o
);

  logic [CNT_W-1:0] pat_q [ALPHABET];
  logic [CNT_W-1:0] pat_d [ALPHABET];
  logic [CNT_W-1:0] win_q [ALPHABET];
  logic [CNT_W-1:0] win_d [ALPHABET];

  always_comb begin
    logic inc;
    logic dec;
    for (int i = 0; i < ALPHABET; i++) begin
      pat_d[i] = pat_q[i];
      win_d[i] = win_q[i];
      inc = ctrl_i.win_inc && (ctrl_i.letter == LETTER_W'(i));
      dec = ctrl_i.win_dec && (ctrl_i.old_letter == LETTER_W'(i)) && (win_q[i] != '0);
      if (ctrl_i.clear) begin
        pat_d[i] = '0;
        win_d[i] = '0;
      end else begin
        if (ctrl_i.pat_inc && (ctrl_i.letter == LETTER_W'(i))) begin
          pat_d[i] = pat_q[i] + 1'b1;
        end
        if (inc && !dec) begin
          win_d[i] = win_q[i] + 1'b1;
        end else if (dec && !inc) begin
          win_d[i] = win_q[i] - 1'b1;
        end
      end
    end
  end

  // The window is compared after this item's update; the pattern does not move during text.
  always_comb begin
    equal_o = 1'b1;
    for (int i = 0; i < ALPHABET; i++) begin
      if (win_d[i] != pat_q[i]) begin
        equal_o = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALPHABET; i++) begin
        pat_q[i] <= '0;
        win_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ALPHABET; i++) begin
        pat_q[i] <= pat_d[i];
        win_q[i] <= win_d[i];
      end
    end
  end

endmodule

// File: hw/rtl/sliding_anagram_window_matcher.sv
// Each input transfer is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless the output stalls; each item updates the
// histograms in a single pass between the input register and the result register.
// An input item is taken while a finished result still waits on the output register.
// Reset clears histograms, counters and the ring pointer at once; the letter ring itself
// is not cleared, since an entry is only read after the current window has written it.
module sliding_anagram_window_matcher import sawm_pkg::*; #(
  parameter int unsigned MAX_PAT  = MAX_PAT_DEF,
  parameter int unsigned POS_BITS = POS_BITS_DEF,
  localparam int unsigned M_DATA_W = ((POS_BITS + 2 + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,   // letter
  input  logic [REQ_W-1:0]    s_axis_tuser,   // req_type
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata    // match, start_position, overflow
);

  localparam int unsigned CNT_W = $clog2(MAX_PAT + 1);
  localparam int unsigned PTR_W = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
  localparam int unsigned TC_W  = POS_BITS + 1;
  localparam int unsigned CMP_W = (TC_W > CNT_W) ? TC_W : CNT_W;
  localparam logic [TC_W-1:0] POS_LIMIT = {1'b1, {POS_BITS{1'b0}}};

  logic                in_valid_q;
  logic [REQ_W-1:0]    req_q;
  letter_t             letter_q;
  logic                out_valid_q;
  logic                match_q;
  logic [POS_BITS-1:0] start_q;
  logic                ovf_out_q;

  logic [CNT_W-1:0] plen_q, plen_d;
  logic [TC_W-1:0]  tc_q, tc_d, tc_new;
  logic [PTR_W-1:0] ptr_q, ptr_d, ptr_wrap;
  logic             ovf_q, ovf_d;

  logic             advance, in_xfer;
  logic             letter_ok, is_clear, pat_ok, is_text, tc_sat, text_act, evict, report;
  logic [CMP_W-1:0] start_full;
  letter_t          old_letter;
  logic             hist_eq;
  hist_ctrl_t       hist_ctrl;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    letter_ok = letter_q < LETTER_W'(ALPHABET);
    is_clear  = req_q == REQ_CLEAR;
    pat_ok    = (req_q == REQ_PATTERN) && letter_ok && (tc_q == '0) &&
                (plen_q < CNT_W'(MAX_PAT));
    is_text   = (req_q == REQ_TEXT) && letter_ok;
    tc_sat    = tc_q == POS_LIMIT;
    tc_new    = (is_text && !tc_sat) ? tc_q + 1'b1 : tc_q;
    text_act  = is_text && (plen_q != '0);
    evict     = text_act && (CMP_W'(tc_q) >= CMP_W'(plen_q));
    report    = text_act && (CMP_W'(tc_new) >= CMP_W'(plen_q));
    start_full = CMP_W'(tc_new) - CMP_W'(plen_q);
    ptr_wrap  = ((CNT_W'(ptr_q) + 1'b1) == plen_q) ? '0 : ptr_q + 1'b1;

    plen_d = plen_q;
    tc_d   = tc_q;
    ptr_d  = ptr_q;
    ovf_d  = ovf_q;
    if (advance) begin
      if (is_clear) begin
        plen_d = '0;
        tc_d   = '0;
        ptr_d  = '0;
        ovf_d  = 1'b0;
      end else begin
        if (pat_ok) begin
          plen_d = plen_q + 1'b1;
        end
        tc_d  = tc_new;
        ovf_d = ovf_q || (is_text && tc_sat);
        if (text_act) begin
          ptr_d = ptr_wrap;
        end
      end
    end
  end

  always_comb begin
    hist_ctrl.clear      = advance && is_clear;
    hist_ctrl.pat_inc    = advance && pat_ok;
    hist_ctrl.win_inc    = advance && text_act;
    hist_ctrl.win_dec    = advance && evict;
    hist_ctrl.letter     = letter_q;
    hist_ctrl.old_letter = old_letter;
  end

  sawm_ring #(
    .DEPTH (MAX_PAT),
    .PTR_W (PTR_W)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (advance && text_act),
    .wr_addr_i (ptr_q),
    .wr_data_i (letter_q),
    .rd_addr_i (ptr_d),
    .rd_data_o (old_letter)
  );

  sawm_hist #(
    .CNT_W (CNT_W)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (hist_ctrl),
    .equal_o (hist_eq)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      plen_q      <= '0;
      tc_q        <= '0;
      ptr_q       <= '0;
      ovf_q       <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      plen_q <= plen_d;
      tc_q   <= tc_d;
      ptr_q  <= ptr_d;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q    <= s_axis_tuser;
      letter_q <= s_axis_tdata[LETTER_W-1:0];
    end
    if (advance) begin
      match_q   <= report && hist_eq;
      start_q   <= report ? start_full[POS_BITS-1:0] : '0;
      ovf_out_q <= ovf_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_DATA_W'({ovf_out_q, start_q, match_q});

endmodule

// File: hw/rtl/sawm_checker.sv
// Port-level checks for the anagram window matcher and the bind that attaches them.
module sawm_checker import sawm_pkg::*; #(
  parameter int unsigned M_DATA_W = 24
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [S_DATA_W-1:0] s_axis_tdata,
  input logic [REQ_W-1:0]    s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [M_DATA_W-1:0] m_axis_tdata
);

  // A stalled result holds until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // The input side only stalls when a result is held and a new one is waiting behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back pressure");

  // Every accepted item must be followed by a valid result on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
    else $error("result missing after an input transfer");

  // Leaving reset, the block is empty and ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid && s_axis_tready)
    else $error("block not empty after reset");

endmodule

bind sliding_anagram_window_matcher sawm_checker #(
  .M_DATA_W (M_DATA_W)
) u_sawm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
